FILE: hw/rtl/dlr_pkg.sv
// Shared constants and types for the DDA line rasterizer.
package dlr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

endpackage

FILE: hw/rtl/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: front end, queue and pixel stepper.
// o_valid follows an accepted step beat through the front-end register, the queue and the pixel output register.
// Throughput: one beat per cycle while no stall holds the flow, set by the error update in the stepper.
// Load beats and step beats with no active line produce no output beat.
// Reset (synchronous, active low) clears the queue, the line's active and start flags, output valid and color register.
module dda_line_rasterizer_top #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_draw_color_we,
    input  logic [dlr_pkg::COLOR_BITS-1:0]  i_draw_color,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_mode,
    input  logic [COORD_BITS-1:0]           i_start_x,
    input  logic [COORD_BITS-1:0]           i_start_y,
    input  logic [COORD_BITS-1:0]           i_end_x,
    input  logic [COORD_BITS-1:0]           i_end_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [COORD_BITS-1:0]           o_pixel_x,
    output logic [COORD_BITS-1:0]           o_pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0]  o_pixel_color,
    output logic                            o_last_pixel
);
    import dlr_pkg::*;

    localparam int ENTRY_W = 5 * COORD_BITS + 3;

    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    dlr_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_mode    (i_mode),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_push    (push),
        .o_entry   (wr_entry),
        .i_full    (full)
    );

    dlr_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (wr_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (rd_entry),
        .o_empty (empty)
    );

    dlr_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_draw_color_we (i_draw_color_we),
        .i_draw_color    (i_draw_color),
        .i_entry         (rd_entry),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

FILE: hw/rtl/dlr_front.sv
// Front end: accepts input beats, classifies loads and sets up line geometry.
module dlr_front #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_push,
    output logic [ENTRY_W-1:0]    o_entry,
    input  logic                  i_full
);
    import dlr_pkg::*;

    localparam int W = COORD_BITS;

    logic                r_valid;
    logic                n_valid;
    logic [ENTRY_W-1:0]  r_entry;
    logic                accept;
    logic                is_load;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic [W:0]          adx;
    logic [W:0]          ady;
    logic                steep;
    logic [W-1:0]        maj_a;
    logic [W-1:0]        maj_b;
    logic [W-1:0]        min_a;
    logic [W-1:0]        min_b;
    logic [W-1:0]        lo_maj;
    logic [W-1:0]        hi_maj;
    logic [W-1:0]        lo_min;
    logic [W-1:0]        hi_min;
    logic [W-1:0]        span_d;
    logic [W:0]          span_m;

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_entry = r_entry;
    assign is_load = (i_mode == MODE_LOAD);

    always_comb begin
        dx  = $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
        dy  = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
        adx = dx[W] ? -dx : dx;
        ady = dy[W] ? -dy : dy;
        steep = ady > adx;
        if (steep) begin
            maj_a = i_start_y;
            min_a = i_start_x;
            maj_b = i_end_y;
            min_b = i_end_x;
        end else begin
            maj_a = i_start_x;
            min_a = i_start_y;
            maj_b = i_end_x;
            min_b = i_end_y;
        end
        if (maj_a > maj_b) begin
            lo_maj = maj_b;
            lo_min = min_b;
            hi_maj = maj_a;
            hi_min = min_a;
        end else begin
            lo_maj = maj_a;
            lo_min = min_a;
            hi_maj = maj_b;
            hi_min = min_b;
        end
        span_d = hi_maj - lo_maj;
        span_m = {1'b0, hi_min} - {1'b0, lo_min};
    end

    always_comb begin
        n_valid = accept || (r_valid && i_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold the classified beat until the queue takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= {is_load, steep, lo_maj, hi_maj, lo_min, span_d, span_m};
        end
    end

endmodule

FILE: hw/rtl/dlr_fifo.sv
// Small queue between the front end and the pixel stepper.
module dlr_fifo #(
    parameter int DATA_W = 5 * dlr_pkg::COORD_BITS_DEF + 3,
    parameter int DEPTH  = dlr_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    import dlr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     n_wr;
    logic [PW-1:0]     r_rd;
    logic [PW-1:0]     n_rd;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_P) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_P) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/dlr_back.sv
// Back end: line state, incremental error stepping and the pixel output register.
module dlr_back #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_draw_color_we,
    input  logic [dlr_pkg::COLOR_BITS-1:0]  i_draw_color,
    input  logic [ENTRY_W-1:0]              i_entry,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [COORD_BITS-1:0]           o_pixel_x,
    output logic [COORD_BITS-1:0]           o_pixel_y,
    output logic [dlr_pkg::COLOR_BITS-1:0]  o_pixel_color,
    output logic                            o_last_pixel
);
    import dlr_pkg::*;

    localparam int W = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic                  e_load;
    logic                  e_steep;
    logic [W-1:0]          e_lo_maj;
    logic [W-1:0]          e_hi_maj;
    logic [W-1:0]          e_lo_min;
    logic [W-1:0]          e_span_d;
    logic [W:0]            e_span_m;

    logic                  r_color_valid;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_active;
    logic                  n_active;
    logic                  r_first;
    logic                  n_first;
    logic                  r_steep;
    logic                  n_steep;
    logic [W-1:0]          r_cur_major;
    logic [W-1:0]          n_cur_major;
    logic [W-1:0]          r_final_major;
    logic [W-1:0]          n_final_major;
    logic [W-1:0]          r_cur_minor;
    logic [W-1:0]          n_cur_minor;
    logic [W-1:0]          r_span_d;
    logic [W-1:0]          n_span_d;
    logic [W:0]            r_span_m;
    logic [W:0]            n_span_m;
    logic signed [E-1:0]   r_err;
    logic signed [E-1:0]   n_err;
    logic signed [E-1:0]   two_d;
    logic signed [E-1:0]   two_m;
    logic signed [E-1:0]   sum;

    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [W-1:0]          r_px;
    logic [W-1:0]          r_py;
    logic [COLOR_BITS-1:0] r_pcolor;
    logic                  r_plast;
    logic                  emit;
    logic                  emit_last;
    logic [W-1:0]          emit_major;
    logic [W-1:0]          emit_minor;

    assign {e_load, e_steep, e_lo_maj, e_hi_maj, e_lo_min, e_span_d, e_span_m} = i_entry;

    assign o_pop         = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last_pixel  = r_plast;

    assign two_d = $signed({2'b00, r_span_d, 1'b0});
    assign two_m = $signed({r_span_m[W], r_span_m, 1'b0});
    assign sum   = r_err + two_m;

    always_comb begin
        n_active      = r_active;
        n_first       = r_first;
        n_steep       = r_steep;
        n_cur_major   = r_cur_major;
        n_final_major = r_final_major;
        n_cur_minor   = r_cur_minor;
        n_span_d      = r_span_d;
        n_span_m      = r_span_m;
        n_err         = r_err;
        emit          = 1'b0;
        emit_major    = r_cur_major;
        emit_minor    = r_cur_minor;
        emit_last     = 1'b0;
        if (o_pop) begin
            if (e_load) begin
                n_active      = 1'b1;
                n_first       = 1'b1;
                n_steep       = e_steep;
                n_cur_major   = e_lo_maj;
                n_final_major = e_hi_maj;
                n_cur_minor   = e_lo_min;
                n_span_d      = e_span_d;
                n_span_m      = e_span_m;
                n_err         = $signed({3'b000, e_span_d});
            end else if (r_active) begin
                emit = 1'b1;
                if (r_first) begin
                    n_first = 1'b0;
                end else begin
                    n_cur_major = r_cur_major + 1'b1;
                    priority if (sum >= two_d) begin
                        n_err       = sum - two_d;
                        n_cur_minor = r_cur_minor + 1'b1;
                    end else if (sum < 0) begin
                        n_err       = sum + two_d;
                        n_cur_minor = r_cur_minor - 1'b1;
                    end else begin
                        n_err = sum;
                    end
                end
                emit_major = n_cur_major;
                emit_minor = n_cur_minor;
                emit_last  = (n_cur_major == r_final_major);
                if (emit_last) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_first       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_color_valid <= 1'b0;
            r_color       <= '0;
        end else begin
            r_active      <= n_active;
            r_first       <= n_first;
            r_out_valid   <= n_out_valid;
            r_color_valid <= r_color_valid || i_draw_color_we;
            if (i_draw_color_we) begin
                r_color <= i_draw_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep       <= n_steep;
        r_cur_major   <= n_cur_major;
        r_final_major <= n_final_major;
        r_cur_minor   <= n_cur_minor;
        r_span_d      <= n_span_d;
        r_span_m      <= n_span_m;
        r_err         <= n_err;
        if (emit) begin
            r_px     <= r_steep ? emit_minor : emit_major;
            r_py     <= r_steep ? emit_major : emit_minor;
            r_pcolor <= r_color_valid ? r_color : '0;
            r_plast  <= emit_last;
        end
    end

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_span_d != '0) |-> (r_err >= 0 && r_err < two_d))
        else $error("rounding error left its range");

    a_major_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cur_major <= r_final_major))
        else $error("major coordinate passed the line end");

    a_first_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> r_active)
        else $error("start pixel pending without an active line");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last && !(o_pop && e_load)) |=> !r_active)
        else $error("line still active after its last pixel");

endmodule
